FILE: rtl/ssdr_pkg.sv
// ----------------------------------------------------------------------------
// ssdr_pkg
// Shared constants, codes and types of the step sequencer with debounce and
// press recording.
// ----------------------------------------------------------------------------
package ssdr_pkg;

  localparam int NUM_STEPS  = 8;
  localparam int MAX_EVENTS = 64;

  localparam int SEG_W = $clog2(NUM_STEPS);
  localparam int IDX_W = $clog2(MAX_EVENTS);
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);

  // round-up reciprocal of NUM_STEPS for an exact 32-bit quotient
  localparam int DIV_SH = $clog2(NUM_STEPS);
  localparam logic [65:0] DIV_MUL =
    ((66'd1 << (32 + DIV_SH)) + 66'(NUM_STEPS) - 66'd1) / 66'(NUM_STEPS);

  typedef enum logic [1:0] {
    MODE_FREE   = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_PLAY   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_FREE   = 3'd1,
    REQ_RECORD = 3'd2,
    REQ_PLAY   = 3'd3,
    REQ_STOP   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    REG_SEQ_LEN  = 2'd0,
    REG_LOCKED   = 2'd1,
    REG_DEBOUNCE = 2'd2
  } reg_e;

  typedef struct packed {
    logic             hit;
    logic [SEG_W-1:0] seg;
  } dbn_hit_t;

  function automatic logic [31:0] div_steps(logic [31:0] x);
    logic [65:0] prod;
    prod = {34'b0, x} * DIV_MUL;
    return prod[32 + DIV_SH +: 32];
  endfunction

endpackage

FILE: rtl/ssdr_debounce.sv
// ----------------------------------------------------------------------------
// ssdr_debounce
// Per-button debounce slots with a lowest-index pick of the confirmed press.
// ----------------------------------------------------------------------------
module ssdr_debounce import ssdr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  logic [NUM_STEPS-1:0] latch_i,
  input  logic [31:0]          time_i,
  input  logic [15:0]          debounce_i,
  output dbn_hit_t             hit_o
);

  logic [NUM_STEPS-1:0] down_q;
  logic [NUM_STEPS-1:0] done_q;
  logic [31:0]          stamp_q [NUM_STEPS];

  logic [NUM_STEPS-1:0] chg;
  logic [NUM_STEPS-1:0] fire;
  logic [NUM_STEPS-1:0] upd_ok;
  logic                 lower;

  always_comb begin
    hit_o = '0;
    lower = 1'b0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      chg[i]    = latch_i[i] ^ down_q[i];
      fire[i]   = !chg[i] && down_q[i] && !done_q[i] &&
                  ((time_i - stamp_q[i]) > {16'b0, debounce_i});
      upd_ok[i] = !lower;
      if (!lower && fire[i]) begin
        hit_o.hit = 1'b1;
        hit_o.seg = SEG_W'(i);
      end
      lower = lower | fire[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= '0;
      done_q <= '0;
    end else if (upd_i) begin
      for (int i = 0; i < NUM_STEPS; i++) begin
        if (upd_ok[i]) begin
          if (chg[i]) begin
            down_q[i] <= latch_i[i];
            done_q[i] <= 1'b0;
          end else if (fire[i]) begin
            done_q[i] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      for (int i = 0; i < NUM_STEPS; i++) begin
        if (upd_ok[i] && chg[i]) begin
          stamp_q[i] <= time_i;
        end
      end
    end
  end

endmodule

FILE: rtl/step_sequencer_with_debounce_record.sv
// ----------------------------------------------------------------------------
// step_sequencer_with_debounce_record
// An accepted word passes from the input register to the result register.
// Throughput: one word per cycle unless out_ready_i stalls the output; each
// word makes a single pass, with one registered event table read.
// Reset clears mode, step, timing, debounce and table count; the event table
// itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module step_sequencer_with_debounce_record import ssdr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        req_type_i,
  input  logic [31:0]       time_ms_i,
  input  logic signed [3:0] override_segment_i,
  input  logic [7:0]        switch_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              step_fired_o,
  output logic [2:0]        fired_segment_o,
  output logic              led_write_o,
  output logic [7:0]        led_pattern_o,
  output logic              record_dropped_o,
  output logic [1:0]        current_mode_o
);

  // configuration
  logic [31:0] seq_len_q;
  logic [31:0] step_div_q;
  logic        locked_q;
  logic [15:0] deb_q;
  logic        cfg_we;
  reg_e        cfg_idx;

  // input register
  logic        item_vld_q;
  logic [2:0]  req_q;
  logic [31:0] time_q;
  logic [3:0]  ovr_q;
  logic [7:0]  sw_q;

  // sequencer state
  mode_e            mode_q, mode_d;
  logic             running_q, running_d;
  logic [3:0]       step_q, step_d;
  logic [31:0]      next_time_q, next_time_d;
  logic [31:0]      step_len_q, step_len_d;
  logic [7:0]       latch_q, latch_d;
  logic [CNT_W-1:0] ev_cnt_q, ev_cnt_d;
  logic [IDX_W-1:0] play_q, play_d;
  logic [31:0]      seq_start_q, seq_start_d;
  logic [3:0]       init_seg_q, init_seg_d;

  // event table
  logic [35:0]      ev_mem [MAX_EVENTS];
  logic [35:0]      rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [35:0]      wr_data;

  // result register
  logic       out_vld_q;
  logic       trig_q, trig_d;
  logic [2:0] act_q, act_d;
  logic       leds_q, leds_d;
  logic [7:0] pat_q, pat_d;
  logic       drop_q, drop_d;

  logic       advance;
  logic       dbn_upd;
  dbn_hit_t   hit;

  logic       ovr_ok;
  logic [4:0] step_inc;
  logic [3:0] step_wrap;
  logic       play_hit;
  logic [IDX_W:0] play_inc;
  logic       store;
  logic [3:0] store_seg;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q  <= '0;
      step_div_q <= '0;
      locked_q   <= 1'b0;
      deb_q      <= 16'd20;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SEQ_LEN: begin
          seq_len_q  <= pwdata;
          step_div_q <= div_steps(pwdata);
        end
        REG_LOCKED:   locked_q <= pwdata[0];
        REG_DEBOUNCE: deb_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SEQ_LEN:  prdata = seq_len_q;
      REG_LOCKED:   prdata = {31'b0, locked_q};
      REG_DEBOUNCE: prdata = {16'b0, deb_q};
      default:      prdata = '0;
    endcase
  end

  // handshake
  assign advance    = item_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q  <= req_type_i;
      time_q <= time_ms_i;
      ovr_q  <= unsigned'(override_segment_i);
      sw_q   <= switch_byte_i;
    end
  end

  assign dbn_upd = advance && (req_q == REQ_TICK) && (mode_q != MODE_PLAY) && !locked_q;

  ssdr_debounce u_dbn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (dbn_upd),
    .latch_i    (latch_q[NUM_STEPS-1:0]),
    .time_i     (time_q),
    .debounce_i (deb_q),
    .hit_o      (hit)
  );

  always_comb begin
    mode_d      = mode_q;
    running_d   = running_q;
    step_d      = step_q;
    next_time_d = next_time_q;
    step_len_d  = step_len_q;
    latch_d     = latch_q;
    ev_cnt_d    = ev_cnt_q;
    play_d      = play_q;
    seq_start_d = seq_start_q;
    init_seg_d  = init_seg_q;
    trig_d      = 1'b0;
    act_d       = '0;
    leds_d      = 1'b0;
    drop_d      = 1'b0;
    store       = 1'b0;
    store_seg   = init_seg_q;

    ovr_ok    = !ovr_q[3] && ({1'b0, ovr_q} < 5'(NUM_STEPS));
    step_inc  = {1'b0, step_q} + 5'd1;
    step_wrap = (step_inc >= 5'(NUM_STEPS)) ? 4'd0 : step_inc[3:0];
    play_hit  = (ev_cnt_q != '0) && ({1'b0, play_q} < ev_cnt_q) &&
                ((time_q - seq_start_q) >= rd_q[35:4]);
    play_inc  = {1'b0, play_q} + 1'b1;

    case (req_q)
      REQ_TICK: begin
        if (mode_q != MODE_FREE && mode_q != MODE_RECORD || !ovr_ok) begin
          if (time_q > next_time_q) begin
            step_d      = step_wrap;
            next_time_d = time_q + step_len_q;
            leds_d      = 1'b1;
          end
        end else if (ovr_q != step_q) begin
          step_d      = ovr_q;
          next_time_d = time_q + step_len_q;
          leds_d      = 1'b1;
        end
        if (mode_q == MODE_PLAY) begin
          if (play_hit) begin
            step_d      = rd_q[3:0];
            act_d       = rd_q[2:0];
            trig_d      = 1'b1;
            leds_d      = 1'b1;
            next_time_d = time_q + step_len_q;
            if (play_inc >= (IDX_W+1)'(ev_cnt_q)) begin
              play_d      = '0;
              seq_start_d = time_q;
            end else begin
              play_d = play_inc[IDX_W-1:0];
            end
          end
        end else begin
          if (!locked_q && hit.hit) begin
            step_d      = 4'(hit.seg);
            act_d       = 3'(hit.seg);
            trig_d      = 1'b1;
            leds_d      = 1'b1;
            next_time_d = time_q + step_len_q;
          end
          latch_d = sw_q;
          if (mode_q == MODE_RECORD && trig_d) begin
            store     = 1'b1;
            store_seg = {1'b0, act_d};
          end
        end
      end
      REQ_FREE: begin
        mode_d      = MODE_FREE;
        ev_cnt_d    = '0;
        play_d      = '0;
        step_len_d  = step_div_q;
        running_d   = 1'b1;
        step_d      = 4'(NUM_STEPS);
        next_time_d = time_q;
      end
      REQ_RECORD: begin
        ev_cnt_d    = '0;
        play_d      = '0;
        mode_d      = MODE_RECORD;
        seq_start_d = time_q;
        init_seg_d  = step_q;
      end
      REQ_PLAY: begin
        mode_d      = MODE_PLAY;
        store       = 1'b1;
        store_seg   = init_seg_q;
        play_d      = '0;
        seq_start_d = time_q;
      end
      REQ_STOP: begin
        running_d = 1'b0;
        mode_d    = MODE_FREE;
      end
      default: ;
    endcase

    mem_we  = 1'b0;
    wr_addr = ev_cnt_q[IDX_W-1:0];
    wr_data = {time_q - seq_start_q, store_seg};
    if (store) begin
      if (ev_cnt_q >= CNT_W'(MAX_EVENTS)) begin
        drop_d = 1'b1;
      end else begin
        mem_we   = advance;
        ev_cnt_d = ev_cnt_q + 1'b1;
      end
    end

    if (leds_d && running_d && ({1'b0, step_d} < 5'(NUM_STEPS))) begin
      pat_d = 8'b1 << step_d[2:0];
    end else begin
      pat_d = '0;
    end
  end

  assign rd_addr = advance ? play_d : play_q;

  // table write and registered read with write bypass
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ev_mem[wr_addr] <= wr_data;
    end
    if (mem_we && wr_addr == rd_addr) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= ev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FREE;
      running_q   <= 1'b0;
      step_q      <= '0;
      next_time_q <= '0;
      step_len_q  <= '0;
      latch_q     <= '0;
      ev_cnt_q    <= '0;
      play_q      <= '0;
      seq_start_q <= '0;
      init_seg_q  <= '0;
    end else if (advance) begin
      mode_q      <= mode_d;
      running_q   <= running_d;
      step_q      <= step_d;
      next_time_q <= next_time_d;
      step_len_q  <= step_len_d;
      latch_q     <= latch_d;
      ev_cnt_q    <= ev_cnt_d;
      play_q      <= play_d;
      seq_start_q <= seq_start_d;
      init_seg_q  <= init_seg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      trig_q <= trig_d;
      act_q  <= act_d;
      leds_q <= leds_d;
      pat_q  <= pat_d;
      drop_q <= drop_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign step_fired_o     = trig_q;
  assign fired_segment_o  = act_q;
  assign led_write_o      = leds_q;
  assign led_pattern_o    = pat_q;
  assign record_dropped_o = drop_q;
  assign current_mode_o   = mode_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_cnt_q <= CNT_W'(MAX_EVENTS))
    else $error("event count beyond table depth");

  a_play_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_PLAY) |-> ({1'b0, play_q} < ev_cnt_q))
    else $error("playback index outside recorded events");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && drop_d) |-> (ev_cnt_q == CNT_W'(MAX_EVENTS)))
    else $error("event dropped with room in table");

  a_pat_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($onehot0(pat_q) && (leds_q || pat_q == '0)))
    else $error("LED pattern not one-hot or sent without write");

endmodule

FILE: verif/ssdr_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdr_result_checker
// Follows the register port and both word channels of the step sequencer,
// keeps its own copy of the sequencer state, works out the result of each
// accepted word and compares every result word field by field, oldest first.
// ----------------------------------------------------------------------------
module ssdr_result_checker import ssdr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [3:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [2:0]        req_type_i,
  input  logic [31:0]       time_ms_i,
  input  logic signed [3:0] override_segment_i,
  input  logic [7:0]        switch_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              step_fired_i,
  input  logic [2:0]        fired_segment_i,
  input  logic              led_write_i,
  input  logic [7:0]        led_pattern_i,
  input  logic              record_dropped_i,
  input  logic [1:0]        current_mode_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic       trig;
    logic [2:0] seg;
    logic       led_wr;
    logic [7:0] leds;
    logic       dropped;
    logic [1:0] mode;
  } step_result_t;

  step_result_t result_q[$];
  step_result_t want;
  int           n_fail = 0;

  logic [31:0]      len_cfg;
  logic             locked_cfg;
  logic [15:0]      debounce_cfg;

  mode_e            mode;
  logic             running;
  logic [3:0]       step_idx;
  logic [31:0]      next_time;
  logic [31:0]      step_len;
  logic [31:0]      seq_start;
  logic [3:0]       init_seg;
  logic [7:0]       sw_latch;
  logic             btn_down  [NUM_STEPS];
  logic [31:0]      btn_stamp [NUM_STEPS];
  logic             btn_done  [NUM_STEPS];
  logic [31:0]      ev_offset [MAX_EVENTS];
  logic [3:0]       ev_seg    [MAX_EVENTS];
  logic [CNT_W-1:0] ev_count;
  logic [CNT_W-1:0] play_idx;

  assign fail_count_o = n_fail;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    n_fail++;
  endtask

  function automatic logic step_forward(input logic [31:0] t, input logic signed [3:0] ovr);
    if (ovr < 0 || ovr >= NUM_STEPS) begin
      if (t > next_time) begin
        step_idx  = (step_idx + 4'd1 >= NUM_STEPS) ? 4'd0 : step_idx + 4'd1;
        next_time = t + step_len;
        return 1'b1;
      end
    end else if (4'(ovr) != step_idx) begin
      step_idx  = 4'(ovr);
      next_time = t + step_len;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic log_event(input logic [31:0] t, input logic [3:0] seg);
    if (ev_count >= MAX_EVENTS) return 1'b0;
    ev_offset[ev_count[IDX_W-1:0]] = t - seq_start;
    ev_seg[ev_count[IDX_W-1:0]]    = seg;
    ev_count++;
    return 1'b1;
  endfunction

  function automatic step_result_t next_result(input logic [2:0] req, input logic [31:0] t,
                                               input logic signed [3:0] ovr,
                                               input logic [7:0] sw);
    step_result_t r;
    logic         trig;
    logic         leds;
    logic         dropped;
    logic [3:0]   seg;
    trig    = 1'b0;
    leds    = 1'b0;
    dropped = 1'b0;
    seg     = 4'd0;
    case (req)
      REQ_TICK: begin
        if (mode == MODE_PLAY) begin
          leds = step_forward(t, -4'sd1);
          if (ev_count > 0 && play_idx < ev_count) begin
            if (t - seq_start >= ev_offset[play_idx[IDX_W-1:0]]) begin
              seg       = ev_seg[play_idx[IDX_W-1:0]];
              step_idx  = seg;
              trig      = 1'b1;
              leds      = 1'b1;
              next_time = t + step_len;
              play_idx++;
              if (play_idx >= ev_count) begin
                play_idx  = '0;
                seq_start = t;
              end
            end
          end
        end else begin
          leds = step_forward(t, ovr);
          if (!locked_cfg) begin
            for (int i = 0; i < NUM_STEPS; i++) begin
              if (!trig) begin
                if (sw_latch[i] != btn_down[i]) begin
                  btn_stamp[i] = t;
                  btn_down[i]  = sw_latch[i];
                  btn_done[i]  = 1'b0;
                end
                if (btn_down[i] && !btn_done[i] && (t - btn_stamp[i]) > debounce_cfg) begin
                  btn_done[i] = 1'b1;
                  step_idx    = 4'(i);
                  seg         = 4'(i);
                  trig        = 1'b1;
                  leds        = 1'b1;
                  next_time   = t + step_len;
                end
              end
            end
          end
          sw_latch = sw;
          if (mode == MODE_RECORD && trig) dropped = !log_event(t, seg);
        end
      end
      REQ_FREE: begin
        mode      = MODE_FREE;
        ev_count  = '0;
        play_idx  = '0;
        step_len  = len_cfg / NUM_STEPS;
        running   = 1'b1;
        step_idx  = 4'(NUM_STEPS);
        next_time = t;
      end
      REQ_RECORD: begin
        ev_count  = '0;
        play_idx  = '0;
        mode      = MODE_RECORD;
        seq_start = t;
        init_seg  = step_idx;
      end
      REQ_PLAY: begin
        mode      = MODE_PLAY;
        dropped   = !log_event(t, init_seg);
        play_idx  = '0;
        seq_start = t;
      end
      REQ_STOP: begin
        running = 1'b0;
        mode    = MODE_FREE;
      end
      default: ;
    endcase
    r.trig    = trig;
    r.seg     = trig ? seg[2:0] : 3'd0;
    r.led_wr  = leds;
    r.leds    = (leds && running && step_idx < NUM_STEPS) ? 8'd1 << step_idx : 8'h00;
    r.dropped = dropped;
    r.mode    = mode;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg      = '0;
      locked_cfg   = 1'b0;
      debounce_cfg = 16'd20;
      mode         = MODE_FREE;
      running      = 1'b0;
      step_idx     = '0;
      next_time    = '0;
      step_len     = '0;
      seq_start    = '0;
      init_seg     = '0;
      sw_latch     = '0;
      ev_count     = '0;
      play_idx     = '0;
      for (int i = 0; i < NUM_STEPS; i++) begin
        btn_down[i]  = 1'b0;
        btn_stamp[i] = '0;
        btn_done[i]  = 1'b0;
      end
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result word with nothing expected",
                          32'({step_fired_i, fired_segment_i, led_write_i,
                               led_pattern_i, record_dropped_i, current_mode_i}), '0);
        end else begin
          want = result_q.pop_front();
          if (step_fired_i !== want.trig)
            report_mismatch("step_fired", 32'(step_fired_i), 32'(want.trig));
          if (fired_segment_i !== want.seg)
            report_mismatch("fired_segment", 32'(fired_segment_i), 32'(want.seg));
          if (led_write_i !== want.led_wr)
            report_mismatch("led_write", 32'(led_write_i), 32'(want.led_wr));
          if (led_pattern_i !== want.leds)
            report_mismatch("led_pattern", 32'(led_pattern_i), 32'(want.leds));
          if (record_dropped_i !== want.dropped)
            report_mismatch("record_dropped", 32'(record_dropped_i), 32'(want.dropped));
          if (current_mode_i !== want.mode)
            report_mismatch("current_mode", 32'(current_mode_i), 32'(want.mode));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_SEQ_LEN:  len_cfg      = pwdata_i;
          REG_LOCKED:   locked_cfg   = pwdata_i[0];
          REG_DEBOUNCE: debounce_cfg = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        result_q.push_back(next_result(req_type_i, time_ms_i, override_segment_i,
                                       switch_byte_i));
      pending_o <= result_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the step sequencer through free play, recording and looped playback
// sessions under changing register settings, with random idling on both word
// channels; a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import ssdr_pkg::*;

  localparam int                ITEM_TARGET = 990;
  localparam int                CYCLE_LIMIT = 1_000_000;
  localparam logic signed [3:0] NO_OVERRIDE = -4'sd1;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [2:0]        req_type_i;
  logic [31:0]       time_ms_i;
  logic signed [3:0] override_segment_i;
  logic [7:0]        switch_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              step_fired_o;
  logic [2:0]        fired_segment_o;
  logic              led_write_o;
  logic [7:0]        led_pattern_o;
  logic              record_dropped_o;
  logic [1:0]        current_mode_o;

  int          fail_count;
  int          pending;
  int          cycles     = 0;
  int          n_sent     = 0;
  int          fill_phase = 0;
  bit          calm       = 1'b0;
  logic [31:0] now_ms     = '0;
  logic [7:0]  held       = '0;

  step_sequencer_with_debounce_record uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .time_ms_i           (time_ms_i),
    .override_segment_i  (override_segment_i),
    .switch_byte_i       (switch_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .step_fired_o        (step_fired_o),
    .fired_segment_o     (fired_segment_o),
    .led_write_o         (led_write_o),
    .led_pattern_o       (led_pattern_o),
    .record_dropped_o    (record_dropped_o),
    .current_mode_o      (current_mode_o)
  );

  ssdr_result_checker u_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel_i              (psel),
    .penable_i           (penable),
    .pwrite_i            (pwrite),
    .pready_i            (pready),
    .paddr_i             (paddr),
    .pwdata_i            (pwdata),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .req_type_i          (req_type_i),
    .time_ms_i           (time_ms_i),
    .override_segment_i  (override_segment_i),
    .switch_byte_i       (switch_byte_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .step_fired_i        (step_fired_o),
    .fired_segment_i     (fired_segment_o),
    .led_write_i         (led_write_o),
    .led_pattern_i       (led_pattern_o),
    .record_dropped_i    (record_dropped_o),
    .current_mode_i      (current_mode_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pause_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] next_delta();
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) return 32'd0;
    if (p < 80) return $urandom_range(1, 8);
    if (p < 95) return $urandom_range(9, 60);
    if (p < 99) return $urandom_range(1000, 100000);
    return $urandom;
  endfunction

  initial begin : drain
    int n;
    out_ready_i <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      n = calm ? 0 : pause_len();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [2:0] req, input logic [31:0] t,
                           input logic signed [3:0] ovr, input logic [7:0] sw);
    int gap;
    gap = calm ? 0 : pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    req_type_i         <= req;
    time_ms_i          <= t;
    override_segment_i <= ovr;
    switch_byte_i      <= sw;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic send_cmd(input req_e req);
    now_ms = now_ms + next_delta();
    send_word(req, now_ms, 4'($urandom), 8'($urandom));
  endtask

  task automatic tick_word(input bit fill);
    logic signed [3:0] ovr;
    int                b;
    now_ms = now_ms + next_delta();
    if (fill) begin
      fill_phase++;
      held = (fill_phase % 9 < 6) ? 8'hFF : 8'h00;
    end else begin
      case ($urandom_range(0, 19))
        0:       held = 8'($urandom);
        1:       held = 8'h00;
        2:       held = 8'hFF;
        default: if ($urandom_range(0, 2) == 0) begin
          b       = $urandom_range(0, 7);
          held[b] = ~held[b];
        end
      endcase
    end
    ovr = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : NO_OVERRIDE;
    send_word(REQ_TICK, now_ms, ovr, held);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input bit fill);
    logic [31:0] len;
    logic [15:0] dbn;
    case ($urandom_range(0, 7))
      0:       len = 32'd0;
      1:       len = 32'hFFFF_FFFF;
      2:       len = $urandom_range(1, 15);
      3, 4:    len = $urandom_range(16, 400);
      5:       len = $urandom_range(400, 5000);
      6:       len = $urandom;
      default: len = 32'(NUM_STEPS);
    endcase
    case ($urandom_range(0, 7))
      0:       dbn = 16'd0;
      1:       dbn = 16'hFFFF;
      2, 3:    dbn = 16'($urandom_range(1, 5));
      4:       dbn = 16'd20;
      default: dbn = 16'($urandom_range(0, 40));
    endcase
    if (fill) dbn = 16'($urandom_range(0, 1));
    write_reg(REG_SEQ_LEN, len);
    write_reg(REG_LOCKED, (!fill && $urandom_range(0, 6) == 0) ? 32'd1 : 32'd0);
    write_reg(REG_DEBOUNCE, {16'd0, dbn});
  endtask

  task automatic run_session();
    int kind;
    bit fill;
    kind = $urandom_range(0, 9);
    fill = (kind >= 8);
    calm = ($urandom_range(0, 4) == 0);
    if (fill || $urandom_range(0, 1) == 1) begin
      wait_idle();
      reconfigure(fill);
    end
    if ($urandom_range(0, 9) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
    if (kind < 3) begin
      send_cmd(REQ_FREE);
      repeat ($urandom_range(15, 50)) tick_word(1'b0);
      if ($urandom_range(0, 1) == 1) begin
        send_cmd(REQ_STOP);
        repeat ($urandom_range(2, 10)) tick_word(1'b0);
      end
    end else if (kind == 3) begin
      repeat ($urandom_range(4, 12))
        send_word(3'($urandom), $urandom, 4'($urandom), 8'($urandom));
    end else begin
      if ($urandom_range(0, 2) == 0) send_cmd(REQ_FREE);
      send_cmd(REQ_RECORD);
      repeat (fill ? 160 : $urandom_range(10, 50)) tick_word(fill);
      send_cmd(REQ_PLAY);
      repeat ($urandom_range(20, 70)) tick_word(1'b0);
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(REQ_STOP);
        tick_word(1'b0);
      end
    end
  endtask

  initial begin : stimulus
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_valid_i         <= 1'b0;
    req_type_i         <= REQ_TICK;
    time_ms_i          <= '0;
    override_segment_i <= NO_OVERRIDE;
    switch_byte_i      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, then codes outside the command set
    send_word(REQ_TICK, 32'd0, NO_OVERRIDE, 8'h00);
    for (int k = int'(REQ_STOP) + 1; k < 8; k++)
      send_word(3'(k), $urandom, 4'($urandom), 8'($urandom));

    // longest loop, buttons locked, longest debounce
    wait_idle();
    write_reg(REG_SEQ_LEN, 32'hFFFF_FFFF);
    write_reg(REG_LOCKED, 32'd1);
    write_reg(REG_DEBOUNCE, 32'h0000_FFFF);
    send_word(REQ_FREE, 32'd10, NO_OVERRIDE, 8'h00);
    send_word(REQ_TICK, 32'd11, NO_OVERRIDE, 8'hFF);
    send_word(REQ_TICK, 32'd12, 4'sd7, 8'hFF);
    send_word(REQ_TICK, 32'd13, 4'sd7, 8'hFF);
    send_word(REQ_TICK, 32'd14, 4'h8, 8'h00);
    send_word(REQ_STOP, 32'd15, NO_OVERRIDE, 8'h00);
    send_word(REQ_TICK, 32'd16, 4'sd3, 8'h00);

    // zero loop, no debounce: presses, record, playback across the time wrap
    wait_idle();
    write_reg(REG_SEQ_LEN, 32'd0);
    write_reg(REG_LOCKED, 32'd0);
    write_reg(REG_DEBOUNCE, 32'd0);
    send_word(REQ_FREE, 32'd100, NO_OVERRIDE, 8'h00);
    send_word(REQ_TICK, 32'd101, NO_OVERRIDE, 8'h24);
    send_word(REQ_TICK, 32'd102, NO_OVERRIDE, 8'h24);
    send_word(REQ_TICK, 32'd103, NO_OVERRIDE, 8'h00);
    send_word(REQ_RECORD, 32'd104, NO_OVERRIDE, 8'h00);
    send_word(REQ_TICK, 32'd105, NO_OVERRIDE, 8'h80);
    send_word(REQ_TICK, 32'd106, NO_OVERRIDE, 8'h80);
    send_word(REQ_TICK, 32'd107, NO_OVERRIDE, 8'h00);
    send_word(REQ_PLAY, 32'd108, NO_OVERRIDE, 8'h00);
    send_word(REQ_TICK, 32'd108, NO_OVERRIDE, 8'h00);
    send_word(REQ_TICK, 32'd109, NO_OVERRIDE, 8'h00);
    send_word(REQ_TICK, 32'hFFFF_FFFF, NO_OVERRIDE, 8'h00);
    send_word(REQ_TICK, 32'd5, NO_OVERRIDE, 8'h00);
    send_word(REQ_STOP, 32'd6, NO_OVERRIDE, 8'h00);
    now_ms = 32'd6;

    while (n_sent < ITEM_TARGET) run_session();

    wait_idle();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
